### src/mmt_pkg.sv
package mmt_pkg;

   localparam int MAX_DIM = 8;
   localparam int ELEM_W  = 16;
   localparam int MUL_W   = 2 * ELEM_W;
   localparam int ACC_W   = 38;
   localparam int INDEX_W = 6;
   localparam int DIM_W   = 4;
   localparam int POS_W   = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_START  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_ROWS  = 3'd0,
      CSR_A_COLS  = 3'd1,
      CSR_B_ROWS  = 3'd2,
      CSR_B_COLS  = 3'd3,
      CSR_TRANS_A = 3'd4,
      CSR_TRANS_B = 3'd5
   } csr_index_type;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_RESULT
   } state_type;

   // control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic acc_first;
   } mac_ctl_type;

endpackage

### src/mmt_if.sv
interface mmt_req_if;
   import mmt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic [INDEX_W-1:0]        elem_index;
   logic signed [ELEM_W-1:0]  elem_value;

   modport source (output valid, output opcode, output elem_index, output elem_value,
                   input ready);
   modport sink (input valid, input opcode, input elem_index, input elem_value,
                 output ready);
endinterface

interface mmt_rsp_if;
   import mmt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ACC_W-1:0]   product;
   logic [POS_W-1:0]          row;
   logic [POS_W-1:0]          col;
   logic                      status;
   logic                      last;

   modport source (output valid, output product, output row, output col,
                   output status, output last, input ready);
   modport sink (input valid, input product, input row, input col,
                 input status, input last, output ready);
endinterface

### src/mmt_mac.sv
module mmt_mac
   import mmt_pkg::*;
(
   input  logic                     clock,
   input  mac_ctl_type              ctl,
   input  logic signed [ELEM_W-1:0] a_val,
   input  logic signed [ELEM_W-1:0] b_val,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [MUL_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] prod_ext;

   assign prod_ext = {{(ACC_W - MUL_W){prod_ff[MUL_W-1]}}, prod_ff};

   always_comb begin
      prod_in = prod_ff;
      if (ctl.mul_en) begin
         prod_in = a_val * b_val;
      end
      acc_in = acc_ff;
      if (ctl.acc_en) begin
         acc_in = ctl.acc_first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### src/matrix_multiply_transpose.sv
// Matrix multiply C = op(A) * op(B) over column-major stores of MAX_DIM*MAX_DIM
// signed Q8.8 elements, each op optionally a transpose. Load items (A or B) are
// written into their store; an unused opcode or an out-of-range load index is
// dropped. A start walks every element of C row by row with one shared multiplier:
// each multiply-accumulate is a registered store read, a registered multiply and
// an accumulate, and each result waits on its transfer; an inner dimension
// mismatch gives one status result. The request side is not ready during that
// walk. Stores are not cleared at reset: reading an element never loaded returns
// an arbitrary value. Dimension registers of 0 act as 1, values above MAX_DIM act
// as MAX_DIM.
module matrix_multiply_transpose
   import mmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mmt_req_if.sink               req,
   mmt_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int XW    = DW + POS_W;

   // configuration registers
   logic [DIM_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic             trans_a_ff, trans_b_ff;

   state_type state_ff, state_in;

   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [AW-1:0] ra_ff, ra_in, cb_ff, cb_in, ia_ff, ia_in, ib_ff, ib_in;
   logic          err_ff, err_in;

   logic signed [ELEM_W-1:0] a_mem [DEPTH];
   logic signed [ELEM_W-1:0] b_mem [DEPTH];
   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;

   logic [DW-1:0] ar, ac, br, bc, m_dim, k_dim, kb_dim, n_dim;
   logic [DW-1:0] i_x, j_x, k_x;
   logic [XW-1:0] i_row, j_col;
   logic          last_k, last_j, last_i, mismatch;
   logic          item_xfer, rsp_xfer, in_range;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] a_k_step, b_k_step, a_i_step, b_j_step;
   logic signed [ACC_W-1:0] acc;
   mac_ctl_type   ctl;

   function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DW'(MAX_DIM);
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   assign ar = clamp_dim(a_rows_ff);
   assign ac = clamp_dim(a_cols_ff);
   assign br = clamp_dim(b_rows_ff);
   assign bc = clamp_dim(b_cols_ff);

   assign m_dim  = trans_a_ff ? ac : ar;
   assign k_dim  = trans_a_ff ? ar : ac;
   assign kb_dim = trans_b_ff ? bc : br;
   assign n_dim  = trans_b_ff ? br : bc;
   assign mismatch = (k_dim != kb_dim);

   assign i_x = DW'(i_ff);
   assign j_x = DW'(j_ff);
   assign k_x = DW'(k_ff);
   assign last_k = (k_x == k_dim - DW'(1));
   assign last_j = (j_x == n_dim - DW'(1));
   assign last_i = (i_x == m_dim - DW'(1));

   // address strides in the column-major stores
   assign a_k_step = trans_a_ff ? AW'(1) : AW'(ar);
   assign a_i_step = trans_a_ff ? AW'(ar) : AW'(1);
   assign b_k_step = trans_b_ff ? AW'(br) : AW'(1);
   assign b_j_step = trans_b_ff ? AW'(1) : AW'(br);

   assign item_xfer = req.valid && req.ready;
   assign rsp_xfer  = rsp.valid && rsp.ready;
   assign in_range  = (32'(req.elem_index) < DEPTH);
   assign wr_addr   = AW'(req.elem_index);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_xfer && req.opcode == OP_START) begin
               state_in = mismatch ? ST_RESULT : ST_READ;
            end
         end
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = last_k ? ST_RESULT : ST_READ;
         ST_RESULT: begin
            if (rsp.ready) begin
               state_in = (err_ff || (last_i && last_j)) ? ST_IDLE : ST_READ;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req.ready     = 1'b0;
      rsp.valid     = 1'b0;
      ctl.mul_en    = 1'b0;
      ctl.acc_en    = 1'b0;
      ctl.acc_first = (k_ff == '0);
      case (state_ff)
         ST_IDLE:   req.ready  = 1'b1;
         ST_READ:   ;
         ST_MUL:    ctl.mul_en = 1'b1;
         ST_ACC:    ctl.acc_en = 1'b1;
         ST_RESULT: rsp.valid  = 1'b1;
         default:   ;
      endcase
   end

   // loop counters and running store addresses
   always_comb begin
      i_in   = i_ff;
      j_in   = j_ff;
      k_in   = k_ff;
      ra_in  = ra_ff;
      cb_in  = cb_ff;
      ia_in  = ia_ff;
      ib_in  = ib_ff;
      err_in = err_ff;
      if (state_ff == ST_IDLE && item_xfer && req.opcode == OP_START) begin
         i_in   = '0;
         j_in   = '0;
         k_in   = '0;
         ra_in  = '0;
         cb_in  = '0;
         ia_in  = '0;
         ib_in  = '0;
         err_in = mismatch;
      end else if (state_ff == ST_ACC) begin
         if (last_k) begin
            k_in = '0;
         end else begin
            k_in  = k_ff + CW'(1);
            ia_in = ia_ff + a_k_step;
            ib_in = ib_ff + b_k_step;
         end
      end else if (rsp_xfer) begin
         if (last_j) begin
            j_in  = '0;
            i_in  = i_ff + CW'(1);
            ra_in = ra_ff + a_i_step;
            cb_in = '0;
            ia_in = ra_ff + a_i_step;
            ib_in = '0;
         end else begin
            j_in  = j_ff + CW'(1);
            cb_in = cb_ff + b_j_step;
            ia_in = ra_ff;
            ib_in = cb_ff + b_j_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         a_rows_ff  <= DIM_W'(8);
         a_cols_ff  <= DIM_W'(8);
         b_rows_ff  <= DIM_W'(8);
         b_cols_ff  <= DIM_W'(8);
         trans_a_ff <= 1'b0;
         trans_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_A_ROWS:  a_rows_ff  <= csr_wdata;
               CSR_A_COLS:  a_cols_ff  <= csr_wdata;
               CSR_B_ROWS:  b_rows_ff  <= csr_wdata;
               CSR_B_COLS:  b_cols_ff  <= csr_wdata;
               CSR_TRANS_A: trans_a_ff <= csr_wdata[0];
               CSR_TRANS_B: trans_b_ff <= csr_wdata[0];
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      ra_ff  <= ra_in;
      cb_ff  <= cb_in;
      ia_ff  <= ia_in;
      ib_ff  <= ib_in;
      err_ff <= err_in;
   end

   // element stores: one write port for loads, one registered read port each
   always_ff @(posedge clock) begin
      if (item_xfer && in_range && req.opcode == OP_LOAD_A) begin
         a_mem[wr_addr] <= req.elem_value;
      end
      a_rd_ff <= a_mem[ia_ff];
   end

   always_ff @(posedge clock) begin
      if (item_xfer && in_range && req.opcode == OP_LOAD_B) begin
         b_mem[wr_addr] <= req.elem_value;
      end
      b_rd_ff <= b_mem[ib_ff];
   end

   mmt_mac u_mac (
      .clock (clock),
      .ctl   (ctl),
      .a_val (a_rd_ff),
      .b_val (b_rd_ff),
      .acc   (acc)
   );

   assign i_row = XW'(i_ff);
   assign j_col = XW'(j_ff);

   // hold the result fields steady until the transfer
   assign rsp.product = err_ff ? '0 : acc;
   assign rsp.row     = err_ff ? '0 : i_row[POS_W-1:0];
   assign rsp.col     = err_ff ? '0 : j_col[POS_W-1:0];
   assign rsp.status  = err_ff ? STATUS_MISMATCH : STATUS_OK;
   assign rsp.last    = err_ff || (last_i && last_j);

endmodule
